// ===== sv/aprc_pkg.sv =====
// Package for the aging page replacer: types, codes, constants and the LFSR step.
package aprc_pkg;

   localparam int PROCESSES   = 8;
   localparam int PAGES       = 64;
   localparam int FRAMES      = 256;
   localparam int ENTRIES     = PROCESSES * PAGES;

   localparam int PID_W       = 3;
   localparam int PAGE_W      = 6;
   localparam int FRAME_W     = 8;
   localparam int HIST_W      = 16;
   localparam int ENT_ADDR_W  = PID_W + PAGE_W;
   localparam int ENT_DATA_W  = 2 + FRAME_W + HIST_W;
   localparam int FRM_DATA_W  = 1 + PID_W + PAGE_W + 1 + 1;
   localparam int COUNT_W     = 9;

   localparam logic [HIST_W-1:0]  HIST_RECENT = 16'hFFFF;
   localparam logic [15:0]        LFSR_TAPS   = 16'hB400;
   localparam logic [COUNT_W-1:0] FRAMES_CNT  = 9'd256;

   // opcodes
   localparam logic [1:0] OP_INIT    = 2'd0;
   localparam logic [1:0] OP_ACCESS  = 2'd1;
   localparam logic [1:0] OP_AGE     = 2'd2;
   localparam logic [1:0] OP_RELEASE = 2'd3;

   // result status codes
   localparam logic [2:0] STAT_HIT        = 3'd0;
   localparam logic [2:0] STAT_FAULT_FREE = 3'd1;
   localparam logic [2:0] STAT_REPLACED   = 3'd2;
   localparam logic [2:0] STAT_NO_VICTIM  = 3'd3;
   localparam logic [2:0] STAT_NO_FRAME   = 3'd4;
   localparam logic [2:0] STAT_DONE       = 3'd5;

   // frame search attempts
   localparam logic [2:0] ATT_NONE    = 3'd0;
   localparam logic [2:0] ATT_OWN_PG  = 3'd1;
   localparam logic [2:0] ATT_UNOWNED = 3'd2;
   localparam logic [2:0] ATT_OWN_PID = 3'd3;
   localparam logic [2:0] ATT_RANDOM  = 3'd4;

   // configuration register indexes
   localparam logic [1:0] REG_RESERVED = 2'd0;
   localparam logic [1:0] REG_FLOOR    = 2'd1;
   localparam logic [1:0] REG_PCOUNT   = 2'd2;
   localparam logic [1:0] REG_SEED     = 2'd3;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [PID_W-1:0]  process_id;
      logic [PAGE_W-1:0] page_number;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [FRAME_W-1:0] frame_number;
      logic [2:0]         attempt_used;
      logic [PAGE_W-1:0]  evicted_page;
      logic [HIST_W-1:0]  evicted_history;
      logic [COUNT_W-1:0] free_frames;
   } rsp_type;

   // page table entry word
   typedef struct packed {
      logic               valid;
      logic               ref_bit;
      logic [FRAME_W-1:0] frame;
      logic [HIST_W-1:0]  hist;
   } entry_type;

   // frame table word
   typedef struct packed {
      logic              owned;
      logic [PID_W-1:0]  owner;
      logic [PAGE_W-1:0] page;
      logic              busy;
      logic              rsvd;
   } frame_type;

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_CLEAR    = 16'h0002,
      S_INIT_MAP = 16'h0004,
      S_ENT_RD   = 16'h0008,
      S_ENT_CHK  = 16'h0010,
      S_AGE_RD   = 16'h0020,
      S_AGE_WR   = 16'h0040,
      S_REL_RD   = 16'h0080,
      S_REL_WR   = 16'h0100,
      S_REL_ENT  = 16'h0200,
      S_VIC_SCAN = 16'h0400,
      S_FR_SCAN  = 16'h0800,
      S_MAP_WR   = 16'h1000,
      S_VF_RD    = 16'h2000,
      S_VF_WR    = 16'h4000,
      S_OUT      = 16'h8000
   } state_type;

   // one step of the 16-bit Galois LFSR
   function automatic logic [15:0] lfsr_next(input logic [15:0] s);
      logic [15:0] r;
      r = {1'b0, s[15:1]};
      if (s[0]) r = r ^ LFSR_TAPS;
      return r;
   endfunction

endpackage

// ===== sv/aprc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module aprc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/aging_page_replacer_top.sv =====
// Aging page replacer: per-process page tables over one shared frame pool.
//
// One result transaction per request transaction. After reset the block runs a
// clearing pass over the page table and frame table memories and takes no
// request until it ends; an init op repeats that pass and then maps the
// reserved pages, one per cycle. A replacing fault makes a victim pass over the
// page table (one entry per cycle) and up to four passes over the frame table
// (one frame per cycle), all bounded by the single read port of each memory.
// Aging reads each page of the process and ages the valid ones; release reads
// each frame and frees those the process owns, then clears its page entries.
// The input side is ready only when the sequencer is idle; a finished result
// waits in the output register.
module aging_page_replacer_top
   import aprc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // configuration registers
   logic [4:0]  reserved_pages_ff;
   logic [8:0]  free_floor_ff;
   logic [3:0]  process_count_ff;
   logic [15:0] random_seed_ff;

   state_type          state_ff, state_in;
   logic               init_ff, init_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [FRAME_W-1:0] pidx_ff, pidx_in;
   logic [2:0]         kind_ff, kind_in;
   logic [FRAME_W-1:0] start_ff, start_in;
   logic               found_ff, found_in;
   logic [HIST_W-1:0]  best_ff, best_in;
   logic [PAGE_W-1:0]  vpage_ff, vpage_in;
   logic [FRAME_W-1:0] vframe_ff, vframe_in;
   logic [FRAME_W-1:0] tgt_ff, tgt_in;
   logic [15:0]        nl_ff, nl_in;
   logic [15:0]        lfsr_ff, lfsr_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [3:0]         ip_ff, ip_in;
   logic [4:0]         ik_ff, ik_in;
   logic [COUNT_W-1:0] if_ff, if_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // memory ports
   logic                  e_we;
   logic [ENT_ADDR_W-1:0] e_waddr, e_raddr;
   entry_type             e_wdata, e_rdata;
   logic                  f_we;
   logic [FRAME_W-1:0]    f_waddr, f_raddr;
   frame_type             f_wdata, f_rdata;

   logic [3:0]         np;
   logic [ENT_ADDR_W-1:0] ent_addr;
   logic               fr_free, fr_match, vic_better, vic_found;
   logic [15:0]        lfsr_step;

   aprc_ram #(.WIDTH(ENT_DATA_W), .DEPTH(ENTRIES)) u_entry_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (e_raddr),
      .rdata (e_rdata)
   );

   aprc_ram #(.WIDTH(FRM_DATA_W), .DEPTH(FRAMES)) u_frame_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   // configuration port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_pages_ff <= 5'd10;
         free_floor_ff     <= 9'd20;
         process_count_ff  <= 4'd8;
         random_seed_ff    <= 16'd1;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_RESERVED: reserved_pages_ff <= pwdata[4:0];
            REG_FLOOR:    free_floor_ff     <= pwdata[8:0];
            REG_PCOUNT:   process_count_ff  <= pwdata[3:0];
            REG_SEED:     random_seed_ff    <= pwdata[15:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_RESERVED: prdata = {27'd0, reserved_pages_ff};
         REG_FLOOR:    prdata = {23'd0, free_floor_ff};
         REG_PCOUNT:   prdata = {28'd0, process_count_ff};
         REG_SEED:     prdata = {16'd0, random_seed_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // shared decode
   assign np        = (process_count_ff > 4'd8) ? 4'd8 : process_count_ff;
   assign ent_addr  = {pid_ff, page_ff};
   assign lfsr_step = lfsr_next(lfsr_ff);
   assign fr_free   = !f_rdata.busy && !f_rdata.rsvd;

   always_comb begin
      case (kind_ff)
         ATT_OWN_PG:  fr_match = fr_free && f_rdata.owned && f_rdata.owner == pid_ff
                                 && f_rdata.page == page_ff;
         ATT_UNOWNED: fr_match = fr_free && !f_rdata.owned;
         ATT_OWN_PID: fr_match = fr_free && f_rdata.owned && f_rdata.owner == pid_ff;
         default:     fr_match = fr_free;
      endcase
   end

   assign vic_better = pend_ff && e_rdata.valid && (!found_ff || e_rdata.hist < best_ff);
   assign vic_found  = found_ff || vic_better;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      init_in   = init_ff;
      pid_in    = pid_ff;
      page_in   = page_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      kind_in   = kind_ff;
      start_in  = start_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      vpage_in  = vpage_ff;
      vframe_in = vframe_ff;
      tgt_in    = tgt_ff;
      nl_in     = nl_ff;
      lfsr_in   = lfsr_ff;
      free_in   = free_ff;
      ip_in     = ip_ff;
      ik_in     = ik_ff;
      if_in     = if_ff;
      res_in    = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      e_we    = 1'b0;
      e_waddr = ent_addr;
      e_wdata = '0;
      e_raddr = ent_addr;
      f_we    = 1'b0;
      f_waddr = tgt_ff;
      f_wdata = '0;
      f_raddr = tgt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pid_in  = req_data.process_id;
               page_in = req_data.page_number;
               cnt_in  = '0;
               init_in = 1'b0;
               res_in  = '0;
               res_in.status = STAT_DONE;
               case (req_data.opcode)
                  OP_INIT: begin
                     init_in  = 1'b1;
                     state_in = S_CLEAR;
                  end
                  OP_ACCESS:  state_in = S_ENT_RD;
                  OP_AGE:     state_in = S_AGE_RD;
                  OP_RELEASE: state_in = S_REL_RD;
                  default:    state_in = S_OUT;
               endcase
            end
         end

         // wipe both tables, one entry per cycle
         S_CLEAR: begin
            e_we    = 1'b1;
            e_waddr = cnt_ff;
            f_we    = 1'b1;
            f_waddr = cnt_ff[FRAME_W-1:0];
            cnt_in  = cnt_ff + 9'd1;
            if (cnt_ff == 9'd511) begin
               free_in = FRAMES_CNT;
               if (init_ff) begin
                  lfsr_in  = (random_seed_ff == 16'd0) ? 16'd1 : random_seed_ff;
                  ip_in    = '0;
                  ik_in    = '0;
                  if_in    = '0;
                  state_in = S_INIT_MAP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // map reserved pages to consecutive frames
         S_INIT_MAP: begin
            if (ip_ff >= np || reserved_pages_ff == 5'd0 || if_ff[8]) begin
               state_in = S_OUT;
            end else begin
               e_we          = 1'b1;
               e_waddr       = {ip_ff[PID_W-1:0], 1'b0, ik_ff};
               e_wdata.valid   = 1'b1;
               e_wdata.ref_bit = 1'b1;
               e_wdata.frame   = if_ff[FRAME_W-1:0];
               e_wdata.hist    = HIST_RECENT;
               f_we          = 1'b1;
               f_waddr       = if_ff[FRAME_W-1:0];
               f_wdata.owned = 1'b1;
               f_wdata.owner = ip_ff[PID_W-1:0];
               f_wdata.page  = {1'b0, ik_ff};
               f_wdata.busy  = 1'b1;
               f_wdata.rsvd  = 1'b1;
               free_in = free_ff - 9'd1;
               if_in   = if_ff + 9'd1;
               if (ik_ff == reserved_pages_ff - 5'd1) begin
                  ik_in = '0;
                  ip_in = ip_ff + 4'd1;
               end else begin
                  ik_in = ik_ff + 5'd1;
               end
            end
         end

         S_ENT_RD: state_in = S_ENT_CHK;

         // hit, allocate or replace
         S_ENT_CHK: begin
            cnt_in  = '0;
            pend_in = 1'b0;
            if (e_rdata.valid) begin
               e_we            = 1'b1;
               e_wdata         = e_rdata;
               e_wdata.ref_bit = 1'b1;
               res_in.status       = STAT_HIT;
               res_in.frame_number = e_rdata.frame;
               state_in = S_OUT;
            end else if (free_ff > free_floor_ff) begin
               kind_in  = ATT_NONE;
               start_in = '0;
               state_in = S_FR_SCAN;
            end else begin
               cnt_in   = {4'd0, reserved_pages_ff};
               found_in = 1'b0;
               state_in = S_VIC_SCAN;
            end
         end

         // smallest history among non-reserved valid pages
         S_VIC_SCAN: begin
            e_raddr = {pid_ff, cnt_ff[PAGE_W-1:0]};
            pend_in = (cnt_ff < 9'd64);
            pidx_in = {2'd0, cnt_ff[PAGE_W-1:0]};
            cnt_in  = cnt_ff + 9'd1;
            if (vic_better) begin
               found_in  = 1'b1;
               best_in   = e_rdata.hist;
               vpage_in  = pidx_ff[PAGE_W-1:0];
               vframe_in = e_rdata.frame;
            end
            if (pend_ff && pidx_ff == 8'd63) begin
               cnt_in  = '0;
               pend_in = 1'b0;
               if (!vic_found) begin
                  res_in.status = STAT_NO_VICTIM;
                  state_in = S_OUT;
               end else begin
                  kind_in  = ATT_OWN_PG;
                  start_in = '0;
                  state_in = S_FR_SCAN;
               end
            end
         end

         // circular pass over the frame table for the current attempt
         S_FR_SCAN: begin
            f_raddr = start_ff + cnt_ff[FRAME_W-1:0];
            pend_in = (cnt_ff < FRAMES_CNT);
            pidx_in = start_ff + cnt_ff[FRAME_W-1:0];
            cnt_in  = cnt_ff + 9'd1;
            if (pend_ff && fr_match) begin
               tgt_in   = pidx_ff;
               state_in = S_MAP_WR;
            end else if (pend_ff && cnt_ff == FRAMES_CNT) begin
               cnt_in  = '0;
               pend_in = 1'b0;
               case (kind_ff)
                  ATT_OWN_PG:  kind_in = ATT_UNOWNED;
                  ATT_UNOWNED: kind_in = ATT_OWN_PID;
                  ATT_OWN_PID: begin
                     kind_in  = ATT_RANDOM;
                     nl_in    = lfsr_step;
                     start_in = lfsr_step[FRAME_W-1:0];
                  end
                  default: begin
                     res_in.status = STAT_NO_FRAME;
                     state_in = S_OUT;
                  end
               endcase
            end
         end

         // map the new page; on replace also drop the victim entry
         S_MAP_WR: begin
            f_we          = 1'b1;
            f_waddr       = tgt_ff;
            f_wdata.owned = 1'b1;
            f_wdata.owner = pid_ff;
            f_wdata.page  = page_ff;
            f_wdata.busy  = 1'b1;
            f_wdata.rsvd  = 1'b0;
            e_we = 1'b1;
            if (kind_ff == ATT_NONE) begin
               e_wdata.valid   = 1'b1;
               e_wdata.ref_bit = 1'b1;
               e_wdata.frame   = tgt_ff;
               e_wdata.hist    = HIST_RECENT;
               free_in = free_ff - 9'd1;
               res_in.status       = STAT_FAULT_FREE;
               res_in.frame_number = tgt_ff;
               state_in = S_OUT;
            end else begin
               e_waddr       = {pid_ff, vpage_ff};
               e_wdata.frame = vframe_ff;
               e_wdata.hist  = best_ff;
               state_in = S_VF_RD;
            end
         end

         S_VF_RD: begin
            e_we            = 1'b1;
            e_wdata.valid   = 1'b1;
            e_wdata.ref_bit = 1'b1;
            e_wdata.frame   = tgt_ff;
            e_wdata.hist    = HIST_RECENT;
            f_raddr  = vframe_ff;
            state_in = S_VF_WR;
         end

         // victim frame keeps its owner and page but is no longer busy
         S_VF_WR: begin
            f_we          = 1'b1;
            f_waddr       = vframe_ff;
            f_wdata.owned = 1'b1;
            f_wdata.owner = pid_ff;
            f_wdata.page  = vpage_ff;
            f_wdata.busy  = 1'b0;
            f_wdata.rsvd  = f_rdata.rsvd;
            if (kind_ff == ATT_RANDOM) lfsr_in = nl_ff;
            res_in.status          = STAT_REPLACED;
            res_in.frame_number    = tgt_ff;
            res_in.attempt_used    = kind_ff;
            res_in.evicted_page    = vpage_ff;
            res_in.evicted_history = best_ff;
            state_in = S_OUT;
         end

         S_AGE_RD: begin
            e_raddr  = {pid_ff, cnt_ff[PAGE_W-1:0]};
            state_in = S_AGE_WR;
         end

         // shift the reference bit into the history
         S_AGE_WR: begin
            e_waddr = {pid_ff, cnt_ff[PAGE_W-1:0]};
            if (e_rdata.valid) begin
               e_we            = 1'b1;
               e_wdata         = e_rdata;
               e_wdata.ref_bit = 1'b0;
               e_wdata.hist    = {e_rdata.ref_bit, e_rdata.hist[HIST_W-1:1]};
            end
            cnt_in = cnt_ff + 9'd1;
            state_in = (cnt_ff == 9'd63) ? S_OUT : S_AGE_RD;
         end

         S_REL_RD: begin
            f_raddr  = cnt_ff[FRAME_W-1:0];
            state_in = S_REL_WR;
         end

         // free every frame the process owns
         S_REL_WR: begin
            f_waddr = cnt_ff[FRAME_W-1:0];
            if (f_rdata.owned && f_rdata.owner == pid_ff) begin
               f_we          = 1'b1;
               f_wdata       = f_rdata;
               f_wdata.owned = 1'b0;
               f_wdata.busy  = 1'b0;
               f_wdata.rsvd  = 1'b0;
               if (f_rdata.busy && free_ff < FRAMES_CNT) free_in = free_ff + 9'd1;
            end
            if (cnt_ff == 9'd255) begin
               cnt_in   = '0;
               state_in = S_REL_ENT;
            end else begin
               cnt_in   = cnt_ff + 9'd1;
               state_in = S_REL_RD;
            end
         end

         S_REL_ENT: begin
            e_we    = 1'b1;
            e_waddr = {pid_ff, cnt_ff[PAGE_W-1:0]};
            cnt_in  = cnt_ff + 9'd1;
            if (cnt_ff == 9'd63) state_in = S_OUT;
         end

         // hand the result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_data_in.free_frames = free_ff;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         init_ff      <= 1'b0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         kind_ff      <= ATT_NONE;
         found_ff     <= 1'b0;
         lfsr_ff      <= 16'd1;
         free_ff      <= FRAMES_CNT;
         ip_ff        <= '0;
         ik_ff        <= '0;
         if_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         kind_ff      <= kind_in;
         found_ff     <= found_in;
         lfsr_ff      <= lfsr_in;
         free_ff      <= free_in;
         ip_ff        <= ip_in;
         ik_ff        <= ik_in;
         if_ff        <= if_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pid_ff      <= pid_in;
      page_ff     <= page_in;
      pidx_ff     <= pidx_in;
      start_ff    <= start_in;
      best_ff     <= best_in;
      vpage_ff    <= vpage_in;
      vframe_ff   <= vframe_in;
      tgt_ff      <= tgt_in;
      nl_ff       <= nl_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
